@@ rtl/multi_channel_soft_timer_bank_assert.svh @@
// assertion macros for the soft timer bank
// used by the top level; no other dependencies
`ifndef MULTI_CHANNEL_SOFT_TIMER_BANK_ASSERT_SVH
`define MULTI_CHANNEL_SOFT_TIMER_BANK_ASSERT_SVH
`ifndef SYNTHESIS
`define MCST_AST_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer bank check failed");
`define MCST_AST_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer bank check failed");
`else
`define MCST_AST_IMP(name, clk, rst, ante, cons)
`define MCST_AST_NXT(name, clk, rst, ante, cons)
`endif
`endif

@@ rtl/mcst_pkg.sv @@
// shared constants, types and helpers for the soft timer bank
// no dependencies
package mcst_pkg;

  localparam int NUM_TIMERS = 8;
  localparam int TA_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int OP_W       = 3;
  localparam int IDX_W      = 3;
  localparam int VAL_W      = 32;
  localparam int ST_W       = 2;
  localparam int MASK_W     = 8;
  localparam int MB_W       = $clog2(MASK_W);
  localparam int CFG_IDX_W  = 2;
  localparam int CMP_W      = 8;

  typedef enum logic [OP_W-1:0] {
    OP_TICK       = 3'd0,
    OP_START      = 3'd1,
    OP_STOP       = 3'd2,
    OP_RESTART    = 3'd3,
    OP_SET_PERIOD = 3'd4,
    OP_QUERY      = 3'd5,
    OP_INIT       = 3'd6
  } op_t;

  typedef enum logic [ST_W-1:0] {
    TS_STOPPED = 2'd0,
    TS_RUNNING = 2'd1,
    TS_EXPIRED = 2'd2
  } tstat_t;

  localparam logic KIND_EVENT = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_PERIODIC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EVENT_EN   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_EV,
    S_QR,
    S_FLUSH,
    S_INIT
  } ctrl_state_t;

  typedef struct packed {
    logic [ST_W-1:0]  state;
    logic [VAL_W-1:0] period;
    logic [VAL_W-1:0] stamp;
  } tword_t;

  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] which;
    logic [ST_W-1:0]  status;
    logic [VAL_W-1:0] remaining;
    logic             last;
  } result_t;

  typedef struct packed {
    logic latch;
    logic now_inc;
    logic scan_clr;
    logic scan_inc;
    logic rd_en;
    logic commit;
    logic q_load;
    logic flush;
    logic init_wr;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            idx_ok;
    logic [OP_W-1:0] lop;
    logic            scan_last;
    logic            emit;
    logic            pend_valid;
    logic            out_free;
  } dp_stat_t;

  function automatic logic mask_bit(logic [MASK_W-1:0] m, logic [TA_W-1:0] i);
    logic r;
    r = 1'b0;
    if (CMP_W'(i) < CMP_W'(MASK_W)) r = m[MB_W'(i)];
    return r;
  endfunction

endpackage

@@ rtl/mcst_in_if.sv @@
// command channel of the soft timer bank
// depends on mcst_pkg
interface mcst_in_if;
  import mcst_pkg::*;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [IDX_W-1:0] timer_index;
  logic [VAL_W-1:0] period_value;

  modport source (output valid, output op, output timer_index, output period_value,
                  input ready);
  modport sink (input valid, input op, input timer_index, input period_value,
                output ready);
endinterface

@@ rtl/mcst_out_if.sv @@
// result channel of the soft timer bank
// depends on mcst_pkg
interface mcst_out_if;
  import mcst_pkg::*;
  logic             valid;
  logic             ready;
  logic             kind;
  logic [IDX_W-1:0] which_timer;
  logic [ST_W-1:0]  timer_status;
  logic [VAL_W-1:0] remaining;
  logic             last;

  modport source (output valid, output kind, output which_timer, output timer_status,
                  output remaining, output last, input ready);
  modport sink (input valid, input kind, input which_timer, input timer_status,
                input remaining, input last, output ready);
endinterface

@@ rtl/mcst_cfg_if.sv @@
// register write channel of the soft timer bank
// depends on mcst_pkg
interface mcst_cfg_if;
  import mcst_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [MASK_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/mcst_ctrl.sv @@
// sequencer of the soft timer bank: accepts beats and steps the timer scan
// depends on mcst_pkg; drives the datapath through ctrl_cmd_t
module mcst_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mcst_pkg::dp_stat_t   st,
  output mcst_pkg::ctrl_cmd_t  cmd
);
  import mcst_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        ev_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign ev_stall = (st.lop == OP_TICK) && st.emit && st.pend_valid && !st.out_free;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          case (op_t'(st.op))
            OP_TICK: begin
              cmd.now_inc  = 1'b1;
              cmd.scan_clr = 1'b1;
              state_next   = S_RD;
            end
            OP_START, OP_STOP, OP_RESTART, OP_SET_PERIOD: begin
              if (st.idx_ok) state_next = S_RD;
            end
            OP_QUERY: begin
              state_next = S_RD;
            end
            OP_INIT: begin
              cmd.scan_clr = 1'b1;
              state_next   = S_INIT;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_EV;
      end
      S_EV: begin
        if (!ev_stall) begin
          cmd.commit = 1'b1;
          if (st.lop == OP_QUERY) begin
            state_next = S_QR;
          end else if (st.lop == OP_TICK) begin
            if (st.scan_last) begin
              state_next = S_FLUSH;
            end else begin
              cmd.scan_inc = 1'b1;
              state_next   = S_RD;
            end
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_QR: begin
        cmd.q_load = 1'b1;
        state_next = S_FLUSH;
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        if (!st.pend_valid || st.out_free) state_next = S_IDLE;
      end
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (st.scan_last) begin
          state_next = S_IDLE;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ rtl/mcst_dp.sv @@
// datapath of the soft timer bank: tick counter, registers, timer memory,
// expiry check, pending result and output register; depends on mcst_pkg and the channels
module mcst_dp (
  input  logic                 clk,
  input  logic                 rst,
  mcst_in_if.sink              req,
  mcst_out_if.source           rsp,
  mcst_cfg_if.sink             cfg,
  input  mcst_pkg::ctrl_cmd_t  cmd,
  output mcst_pkg::dp_stat_t   st
);
  import mcst_pkg::*;

  logic [MASK_W-1:0]     periodic_mask;
  logic [MASK_W-1:0]     auto_start_mask;
  logic [MASK_W-1:0]     event_enable_mask;
  logic [VAL_W-1:0]      now_count;
  logic [OP_W-1:0]       lop;
  logic [IDX_W-1:0]      lidx;
  logic                  lidx_ok;
  logic [VAL_W-1:0]      lval;
  logic [TA_W-1:0]       scan;
  logic [TA_W-1:0]       addr;
  tword_t                mem [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] written;
  tword_t                rd_word;
  logic                  rd_ok;
  tword_t                cur;
  tword_t                wdata;
  logic                  we;
  logic                  idx_ok;
  logic [VAL_W-1:0]      elapsed;
  logic [VAL_W-1:0]      q_elapsed;
  logic [VAL_W:0]        q_diff;
  logic                  hit;
  logic                  periodic;
  logic                  ev_en;
  logic                  auto_on;
  logic                  push_ev;
  logic                  move_mid;
  logic                  move_fin;
  logic                  out_free;
  result_t               ev_res;
  result_t               q_res;
  result_t               pend;
  logic                  pend_valid;
  result_t               out_d;
  result_t               out_q;
  logic                  out_valid;

  // register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      periodic_mask     <= '0;
      auto_start_mask   <= '0;
      event_enable_mask <= '1;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_PERIODIC:   periodic_mask     <= cfg.data;
        CFG_AUTO_START: auto_start_mask   <= cfg.data;
        CFG_EVENT_EN:   event_enable_mask <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_count <= '0;
    end else if (cmd.now_inc) begin
      now_count <= now_count + VAL_W'(1);
    end
  end

  assign idx_ok = CMP_W'(req.timer_index) < CMP_W'(NUM_TIMERS);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      lop     <= req.op;
      lidx    <= req.timer_index;
      lval    <= req.period_value;
      lidx_ok <= idx_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= '0;
    end else if (cmd.scan_clr) begin
      scan <= '0;
    end else if (cmd.scan_inc) begin
      scan <= scan + TA_W'(1);
    end
  end

  assign addr = ((lop == OP_TICK) || (lop == OP_INIT)) ? scan : TA_W'(lidx);

  // timer memory, one read and one write port
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    if (cmd.rd_en) rd_word <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (we) begin
      written[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) rd_ok <= written[addr];
  end

  // entries never written read as stopped with zero period and stamp
  assign cur = (rd_ok && (lidx_ok || (lop == OP_TICK))) ? rd_word : '0;

  assign periodic = mask_bit(periodic_mask, scan);
  assign ev_en    = mask_bit(event_enable_mask, scan);
  assign auto_on  = mask_bit(auto_start_mask, scan);
  assign elapsed  = now_count - cur.stamp;
  assign hit      = (cur.state == TS_RUNNING) && !(elapsed < cur.period);

  always_comb begin
    wdata = cur;
    we    = 1'b0;
    if (cmd.init_wr) begin
      we           = 1'b1;
      wdata.state  = auto_on ? TS_RUNNING : TS_STOPPED;
      wdata.period = '0;
      wdata.stamp  = auto_on ? now_count : '0;
    end else if (cmd.commit) begin
      case (op_t'(lop))
        OP_TICK: begin
          if (hit) begin
            we = 1'b1;
            if (periodic) begin
              wdata.stamp = now_count;
            end else begin
              wdata.state = TS_EXPIRED;
            end
          end
        end
        OP_START, OP_RESTART: begin
          we          = 1'b1;
          wdata.state = TS_RUNNING;
          wdata.stamp = now_count;
        end
        OP_STOP: begin
          we          = 1'b1;
          wdata.state = TS_STOPPED;
        end
        OP_SET_PERIOD: begin
          we           = 1'b1;
          wdata.period = lval;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && (lop == OP_QUERY)) q_elapsed <= elapsed;
  end

  assign q_diff = {1'b0, cur.period} - {1'b0, q_elapsed};

  always_comb begin
    ev_res           = '0;
    ev_res.kind      = KIND_EVENT;
    ev_res.which     = IDX_W'(scan);
    ev_res.status    = periodic ? TS_RUNNING : TS_EXPIRED;
    ev_res.remaining = periodic ? cur.period : '0;
    q_res            = '0;
    q_res.kind       = KIND_QUERY;
    q_res.which      = lidx;
    q_res.status     = cur.state;
    q_res.remaining  = ((cur.state == TS_RUNNING) && !q_diff[VAL_W]) ?
                       q_diff[VAL_W-1:0] : '0;
  end

  // pending result holds one beat until it is known whether it is the last
  assign out_free = !out_valid || rsp.ready;
  assign push_ev  = cmd.commit && (lop == OP_TICK) && hit && ev_en;
  assign move_mid = push_ev && pend_valid;
  assign move_fin = cmd.flush && pend_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (push_ev || cmd.q_load) begin
      pend_valid <= 1'b1;
    end else if (move_fin) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ev) begin
      pend <= ev_res;
    end else if (cmd.q_load) begin
      pend <= q_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move_mid || move_fin) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    out_d      = pend;
    out_d.last = move_fin;
  end

  always_ff @(posedge clk) begin
    if (move_mid || move_fin) begin
      out_q <= out_d;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.kind         = out_q.kind;
  assign rsp.which_timer  = out_q.which;
  assign rsp.timer_status = out_q.status;
  assign rsp.remaining    = out_q.remaining;
  assign rsp.last         = out_q.last;

  always_comb begin
    st            = '0;
    st.op         = req.op;
    st.idx_ok     = idx_ok;
    st.lop        = lop;
    st.scan_last  = (scan == TA_W'(NUM_TIMERS - 1));
    st.emit       = hit && ev_en;
    st.pend_valid = pend_valid;
    st.out_free   = out_free;
  end

endmodule

@@ rtl/multi_channel_soft_timer_bank.sv @@
// top level of the soft timer bank: sequencer plus datapath
// depends on mcst_pkg, the channel interfaces, mcst_ctrl, mcst_dp and the assertion macros
//
//   channel  role    beat contents
//   req      sink    op, timer_index, period_value
//   rsp      source  kind, which_timer, timer_status, remaining, last
//   cfg      sink    index, data (always ready)
//
// tick: per timer one memory read state (S_RD) and one evaluate state (S_EV) on the timer
// memory, then S_FLUSH; start, stop, restart, set period: S_RD then S_EV; query: S_RD, S_EV,
// S_QR, then S_FLUSH; init: one S_INIT write per timer; others stay in S_IDLE
// a stalled rsp holds the scan only when a second expiry beat has nowhere to go
// reset clears per-entry written bits, no clearing pass
`include "multi_channel_soft_timer_bank_assert.svh"
module multi_channel_soft_timer_bank (
  input logic        clk,
  input logic        rst,
  mcst_in_if.sink    req,
  mcst_out_if.source rsp,
  mcst_cfg_if.sink   cfg
);
  import mcst_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  st;
  logic      in_ready;
  logic      rsp_expired;

  assign req.ready = in_ready;

  mcst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  mcst_dp u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg),
    .cmd (cmd),
    .st  (st)
  );

  assign rsp_expired = rsp.valid && (rsp.timer_status == TS_EXPIRED);

  `MCST_AST_IMP(a_idle_no_pend, clk, rst, req.ready, !st.pend_valid)
  `MCST_AST_IMP(a_query_last, clk, rst, rsp.valid && (rsp.kind == KIND_QUERY), rsp.last)
  `MCST_AST_IMP(a_expired_zero, clk, rst, rsp_expired, rsp.remaining == '0)
  `MCST_AST_NXT(a_query_busy, clk, rst, req.valid && req.ready && (req.op == OP_QUERY), !req.ready)

endmodule

@@ tb/sv/tb_multi_channel_soft_timer_bank.sv @@
// self-checking testbench for the soft timer bank: directed table, then random phases
// uses mcst_pkg, the req/rsp/cfg channel interfaces and the multi_channel_soft_timer_bank top
module tb_multi_channel_soft_timer_bank;
  timeunit 1ns;
  timeprecision 1ps;
  import mcst_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int SETTLE_CYCLES = 4 * NUM_TIMERS + 8;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 55;
  localparam int PRESSURE_PHASE = 4;
  localparam result_t NO_BEAT = '0;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] pv;
    logic             fixed_ok;
    result_t          fixed;
  } cmd_row_t;

  localparam int DIR_ROWS = 26;
  localparam cmd_row_t DIR_TABLE [DIR_ROWS] = '{
    '{OP_QUERY,      3'd0, 32'd0,           1'b1, '{KIND_QUERY, 3'd0, TS_STOPPED, 32'd0, 1'b1}},
    '{OP_QUERY,      3'd7, 32'd0,           1'b1, '{KIND_QUERY, 3'd7, TS_STOPPED, 32'd0, 1'b1}},
    '{OP_UNUSED,     3'd3, 32'hFFFF_FFFF,   1'b0, NO_BEAT},
    '{OP_SET_PERIOD, 3'd0, 32'd0,           1'b0, NO_BEAT},
    '{OP_SET_PERIOD, 3'd7, 32'hFFFF_FFFF,   1'b0, NO_BEAT},
    '{OP_SET_PERIOD, 3'd3, 32'd3,           1'b0, NO_BEAT},
    '{OP_START,      3'd0, 32'd0,           1'b0, NO_BEAT},
    '{OP_START,      3'd7, 32'd0,           1'b0, NO_BEAT},
    '{OP_RESTART,    3'd3, 32'd0,           1'b0, NO_BEAT},
    '{OP_QUERY,      3'd7, 32'd0,           1'b1,
      '{KIND_QUERY, 3'd7, TS_RUNNING, 32'hFFFF_FFFF, 1'b1}},
    '{OP_TICK,       3'd0, 32'd0,           1'b0, NO_BEAT},
    '{OP_QUERY,      3'd0, 32'd0,           1'b1, '{KIND_QUERY, 3'd0, TS_EXPIRED, 32'd0, 1'b1}},
    '{OP_TICK,       3'd5, 32'd0,           1'b0, NO_BEAT},
    '{OP_TICK,       3'd2, 32'd0,           1'b0, NO_BEAT},
    '{OP_QUERY,      3'd3, 32'd0,           1'b1, '{KIND_QUERY, 3'd3, TS_EXPIRED, 32'd0, 1'b1}},
    '{OP_STOP,       3'd7, 32'd0,           1'b0, NO_BEAT},
    '{OP_QUERY,      3'd7, 32'd0,           1'b1, '{KIND_QUERY, 3'd7, TS_STOPPED, 32'd0, 1'b1}},
    '{OP_SET_PERIOD, 3'd5, 32'd1,           1'b0, NO_BEAT},
    '{OP_START,      3'd5, 32'd0,           1'b0, NO_BEAT},
    '{OP_SET_PERIOD, 3'd2, 32'h5555_AAAA,   1'b0, NO_BEAT},
    '{OP_START,      3'd2, 32'd0,           1'b0, NO_BEAT},
    '{OP_TICK,       3'd0, 32'd0,           1'b0, NO_BEAT},
    '{OP_QUERY,      3'd2, 32'd0,           1'b0, NO_BEAT},
    '{OP_INIT,       3'd6, 32'd0,           1'b0, NO_BEAT},
    '{OP_QUERY,      3'd5, 32'd0,           1'b1, '{KIND_QUERY, 3'd5, TS_STOPPED, 32'd0, 1'b1}},
    '{OP_TICK,       3'd1, 32'd0,           1'b0, NO_BEAT}
  };

  localparam logic [MASK_W-1:0] PH_PERIODIC [PHASES] = '{8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00};
  localparam logic [MASK_W-1:0] PH_AUTO [PHASES]     = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00};
  localparam logic [MASK_W-1:0] PH_EVENT [PHASES]    = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00};
  localparam bit PH_RANDOM_CFG [PHASES]              = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
  localparam int PH_SEND_IDLE [PHASES]               = '{0, 46, 0, 28, 0, 28};
  localparam int PH_STALL [PHASES]                   = '{0, 0, 46, 28, 0, 28};

  logic clk;
  logic rst;

  mcst_in_if  req_ch ();
  mcst_out_if rsp_ch ();
  mcst_cfg_if cfg_ch ();

  multi_channel_soft_timer_bank DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  logic [VAL_W-1:0]  tick_count;
  logic [VAL_W-1:0]  timer_stamp [NUM_TIMERS];
  logic [VAL_W-1:0]  timer_period [NUM_TIMERS];
  tstat_t            timer_state [NUM_TIMERS];
  logic [MASK_W-1:0] per_mask;
  logic [MASK_W-1:0] auto_mask;
  logic [MASK_W-1:0] event_mask;

  result_t awaited_beats [$];
  int fail_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_reqs = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [VAL_W-1:0] time_left(int i);
    logic [VAL_W-1:0] elapsed;
    elapsed = tick_count - timer_stamp[i];
    if (timer_state[i] != TS_RUNNING || elapsed >= timer_period[i]) return '0;
    return timer_period[i] - elapsed;
  endfunction

  function automatic void predict_timer_beats(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                              logic [VAL_W-1:0] pv, logic fixed_ok,
                                              result_t fixed);
    result_t batch [$];
    logic [VAL_W-1:0] elapsed;
    case (op)
      OP_TICK: begin
        tick_count = tick_count + 1'b1;
        for (int i = 0; i < NUM_TIMERS; i++) begin
          elapsed = tick_count - timer_stamp[i];
          if (timer_state[i] == TS_RUNNING && elapsed >= timer_period[i]) begin
            if (per_mask[i]) timer_stamp[i] = tick_count;
            else timer_state[i] = TS_EXPIRED;
            if (event_mask[i])
              batch.push_back('{KIND_EVENT, IDX_W'(i), timer_state[i], time_left(i), 1'b0});
          end
        end
      end
      OP_START, OP_RESTART: begin
        timer_stamp[idx] = tick_count;
        timer_state[idx] = TS_RUNNING;
      end
      OP_STOP: timer_state[idx] = TS_STOPPED;
      OP_SET_PERIOD: timer_period[idx] = pv;
      OP_QUERY: batch.push_back('{KIND_QUERY, idx, timer_state[idx], time_left(idx), 1'b0});
      OP_INIT: begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
          timer_period[i] = '0;
          timer_stamp[i] = auto_mask[i] ? tick_count : '0;
          timer_state[i] = auto_mask[i] ? TS_RUNNING : TS_STOPPED;
        end
      end
      default: ;
    endcase
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    if (fixed_ok) awaited_beats.push_back(fixed);
    else foreach (batch[k]) awaited_beats.push_back(batch[k]);
  endfunction

  // entered and left at a falling edge
  task automatic send_cmd(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] pv,
                          logic fixed_ok, result_t fixed);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.op           <= op;
    req_ch.timer_index  <= idx;
    req_ch.period_value <= pv;
    do @(posedge clk); while (!req_ch.ready);
    predict_timer_beats(op, idx, pv, fixed_ok, fixed);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [MASK_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (index)
      CFG_PERIODIC:   per_mask = data;
      CFG_AUTO_START: auto_mask = data;
      CFG_EVENT_EN:   event_mask = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (awaited_beats.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // receiver: random stalls, plus long hold-offs on request
  initial begin
    int holds_seen;
    int hold_left;
    holds_seen = 0;
    hold_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != holds_seen) begin
        holds_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic void check_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (awaited_beats.size() == 0) begin
        $error("result beat with nothing expected: timer %0d kind %0d",
               rsp_ch.which_timer, rsp_ch.kind);
        fail_count++;
      end else begin
        want = awaited_beats.pop_front();
        check_field("kind", VAL_W'(want.kind), VAL_W'(rsp_ch.kind));
        check_field("which_timer", VAL_W'(want.which), VAL_W'(rsp_ch.which_timer));
        check_field("timer_status", VAL_W'(want.status), VAL_W'(rsp_ch.timer_status));
        check_field("remaining", want.remaining, rsp_ch.remaining);
        check_field("last", VAL_W'(want.last), VAL_W'(rsp_ch.last));
      end
    end
  end

  initial begin
    int r;
    logic [OP_W-1:0] op;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.op = '0;
    req_ch.timer_index = '0;
    req_ch.period_value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    tick_count = '0;
    per_mask = '0;
    auto_mask = '0;
    event_mask = '1;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      timer_stamp[i] = '0;
      timer_period[i] = '0;
      timer_state[i] = TS_STOPPED;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int n = 0; n < DIR_ROWS; n++)
      send_cmd(DIR_TABLE[n].op, DIR_TABLE[n].idx, DIR_TABLE[n].pv, DIR_TABLE[n].fixed_ok,
               DIR_TABLE[n].fixed);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      if (PH_RANDOM_CFG[ph]) begin
        write_reg(CFG_PERIODIC, MASK_W'($urandom()));
        write_reg(CFG_AUTO_START, MASK_W'($urandom()));
        write_reg(CFG_EVENT_EN, MASK_W'($urandom()));
      end else begin
        write_reg(CFG_PERIODIC, PH_PERIODIC[ph]);
        write_reg(CFG_AUTO_START, PH_AUTO[ph]);
        write_reg(CFG_EVENT_EN, PH_EVENT[ph]);
      end
      cfg_ch.valid <= 1'b0;
      send_idle_pct = PH_SEND_IDLE[ph];
      stall_pct = PH_STALL[ph];
      send_cmd(OP_INIT, IDX_W'($urandom()), $urandom(), 1'b0, NO_BEAT);
      if (ph == PRESSURE_PHASE) hold_reqs++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(99);
        if (r < 34) op = OP_TICK;
        else if (r < 46) op = OP_SET_PERIOD;
        else if (r < 58) op = OP_START;
        else if (r < 66) op = OP_RESTART;
        else if (r < 74) op = OP_STOP;
        else if (r < 94) op = OP_QUERY;
        else if (r < 97) op = OP_INIT;
        else op = OP_UNUSED;
        send_cmd(op, IDX_W'($urandom_range(NUM_TIMERS - 1)),
                 ($urandom_range(4) == 0) ? $urandom() : VAL_W'($urandom_range(12)),
                 1'b0, NO_BEAT);
      end
    end

    send_idle_pct = 0;
    stall_pct = 0;
    drain_results();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/mcst_pkg.sv
rtl/mcst_in_if.sv
rtl/mcst_out_if.sv
rtl/mcst_cfg_if.sv
rtl/mcst_ctrl.sv
rtl/mcst_dp.sv
rtl/multi_channel_soft_timer_bank.sv
tb/sv/tb_multi_channel_soft_timer_bank.sv
